### rtl/core/hsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared widths, scale constants and shade tables for the HSL shade palette.
// ----------------------------------------------------------------------------
package hsp_pkg;

  // Fixed-point format of saturation and lightness
  localparam int unsigned FRAC_BITS = 12;

  // Field widths
  localparam int unsigned HUE_W     = 16;
  localparam int unsigned FRAC_IN_W = 13;
  localparam int unsigned KW        = 4;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned CH_W      = 8;

  localparam int unsigned SHADE_COUNT = 11;
  localparam logic [KW-1:0] LAST_SHADE = KW'(SHADE_COUNT - 1);

  // Scale: D = 100 * ONE represents 1.0 after the shade adjustment
  localparam longint unsigned ONE    = 64'd1 << FRAC_BITS;
  localparam longint unsigned DSCALE = 64'd100 * ONE;
  localparam longint unsigned D2     = DSCALE * DSCALE;

  localparam int unsigned LW  = $clog2(DSCALE + 1);        // l, s
  localparam int unsigned PW  = FRAC_IN_W + 7;             // field * 100
  localparam int unsigned MW  = (LW > PW) ? LW : PW;       // compare width
  localparam int unsigned AW  = MW + 2;                    // signed lightness sum
  localparam int unsigned CW  = 2 * LW;                    // chroma at scale D^2
  localparam int unsigned VW  = $clog2(D2 * 1920 + 1);     // channel at scale D^2*1920

  // Hue handling
  localparam int unsigned HUE_PERIOD = 5760;
  localparam int unsigned SECTOR_LEN = 960;
  localparam int unsigned SECTORS    = 6;
  localparam int unsigned HUE_WRAPS  = ((1 << HUE_W) - 1) / HUE_PERIOD;
  localparam int unsigned HW         = 13;                 // reduced hue
  localparam int unsigned TW         = 10;                 // interpolation numerator
  localparam int unsigned SECW       = 3;

  // Channel rounding: round(v*255/(D^2*1920)) = floor((17v >> SH) + 5000) / 10000
  localparam int unsigned SH         = 2 * FRAC_BITS + 7;
  localparam int unsigned NW         = 23;
  localparam int unsigned ROUND_BIAS = 5000;
  // floor(n/10000) = (n * RECIP) >> RECIP_SH, exact for n < 2^NW
  localparam int unsigned RW         = 23;
  localparam longint unsigned RECIP  = 64'd6871948;
  localparam int unsigned RECIP_SH   = 36;

  // Shade tables in hundredths, lightest shade first
  localparam logic signed [7:0] LIGHT_OFF [SHADE_COUNT] = '{
    8'sd35, 8'sd28, 8'sd20, 8'sd12, 8'sd6, 8'sd0,
    -8'sd8, -8'sd16, -8'sd26, -8'sd38, -8'sd48
  };
  localparam logic [6:0] SAT_FAC [SHADE_COUNT] = '{
    7'd35, 7'd50, 7'd70, 7'd85, 7'd95, 7'd100,
    7'd95, 7'd85, 7'd70, 7'd55, 7'd40
  };

  // Sequencer to datapath: one shade request per cycle while the pipeline advances
  typedef struct packed {
    logic                 valid;
    logic [KW-1:0]        k;
    logic [HUE_W-1:0]     hue;
    logic [FRAC_IN_W-1:0] sat;
    logic [FRAC_IN_W-1:0] lig;
  } hsp_seq_t;

endpackage

### rtl/core/hsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_in_if / hsp_out_if
// Valid/ready channels for base colors in and palette shades out.
// ----------------------------------------------------------------------------
interface hsp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [hsp_pkg::HUE_W-1:0]             hue;
  logic [hsp_pkg::FRAC_IN_W-1:0]         saturation;
  logic [hsp_pkg::FRAC_IN_W-1:0]         lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

interface hsp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [hsp_pkg::KW-1:0]                shade_index;
  logic [hsp_pkg::PIX_W-1:0]             pixel565;
  logic                                  last;

  modport source (output valid, shade_index, pixel565, last, input ready);
  modport sink   (input valid, shade_index, pixel565, last, output ready);
endinterface

### rtl/core/hsl_shade_palette_rgb565_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_shade_palette_rgb565_core
// HSL base color in, eleven RGB565 shades out, lightest first.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : valid/ready, one base color per item (hue in 1/16 degree,
//           saturation and lightness Q1.12).
//   out_o : valid/ready, eleven items per base color: shade_index 0..10,
//           pixel565 (R 15:11, G 10:5, B 4:0) and last on shade 10.
// Throughput: one shade per cycle while out_o is not stalled; the next color
//   is taken in the cycle its predecessor issues its last shade.
// Path: the first shade of an input item passes the sequencer, five
//   arithmetic stages, two rounding stages and the output register.
// The single shade issue slot of the sequencer sets the rate.
// Stall: when out_o holds an item that is not taken, the whole pipeline and
//   the sequencer freeze; in_i.ready drops. Nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous): all stage valid bits and the sequencer
//   clear; the block is ready for a new item right after reset.
// ----------------------------------------------------------------------------
module hsl_shade_palette_rgb565_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsp_in_if.sink     in_i,
  hsp_out_if.source  out_o
);
  import hsp_pkg::*;

  hsp_seq_t seq;
  logic     adv;

  hsp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .in_i   (in_i),
    .seq_o  (seq)
  );

  hsp_pipe u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seq_i  (seq),
    .adv_o  (adv),
    .out_o  (out_o)
  );

  // A taken item starts its run at the lightest shade
  a_start_shade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (seq.valid && (seq.k == '0)))
    else $error("run does not start at shade 0");

  // Input is only taken while the pipeline advances
  a_ready_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> adv)
    else $error("input taken during stall");

  // A new item is only taken when no shades of the previous one remain to issue
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (!seq.valid || (seq.k == LAST_SHADE)))
    else $error("item taken mid-run");

  // Last mark follows the shade number
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last == (out_o.shade_index == LAST_SHADE)))
    else $error("last mark out of step with shade index");

endmodule

### rtl/core/hsp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_seq
// Holds one base color and issues its eleven shade requests, one per cycle while adv_i is high.
// ----------------------------------------------------------------------------
module hsp_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  hsp_in_if.sink            in_i,
  output hsp_pkg::hsp_seq_t seq_o
);
  import hsp_pkg::*;

  logic                 active_q;
  logic [KW-1:0]        k_q;
  logic [HUE_W-1:0]     hue_q;
  logic [FRAC_IN_W-1:0] sat_q;
  logic [FRAC_IN_W-1:0] lig_q;
  logic                 accept;

  // Next item may load while the last shade of the current one issues
  assign in_i.ready = adv_i && (!active_q || (k_q == LAST_SHADE));
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      k_q      <= '0;
    end else if (adv_i) begin
      if (accept) begin
        active_q <= 1'b1;
        k_q      <= '0;
      end else if (active_q) begin
        if (k_q == LAST_SHADE) begin
          active_q <= 1'b0;
        end else begin
          k_q <= k_q + KW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hue_q <= in_i.hue;
      sat_q <= in_i.saturation;
      lig_q <= in_i.lightness;
    end
  end

  assign seq_o.valid = active_q;
  assign seq_o.k     = k_q;
  assign seq_o.hue   = hue_q;
  assign seq_o.sat   = sat_q;
  assign seq_o.lig   = lig_q;

endmodule

### rtl/core/hsp_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_chan
// Scales one channel by 255, rounds half up and clamps to 8 bits (2 stages).
// ----------------------------------------------------------------------------
module hsp_chan (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [hsp_pkg::VW-1:0]    v_i,
  output logic [hsp_pkg::CH_W-1:0]  byte_o
);
  import hsp_pkg::*;

  logic [VW+4:0]      v17;
  logic [NW-1:0]      n_d, n_q;
  logic [NW+RW-1:0]   prod;
  logic [NW+RW-RECIP_SH-1:0] quo;
  logic [CH_W-1:0]    byte_d, byte_q;

  // Stage A: n = (17v >> SH) + half of the divisor
  always_comb begin
    v17 = ((VW+5)'(v_i) << 4) + (VW+5)'(v_i);
    n_d = NW'(v17 >> SH) + NW'(ROUND_BIAS);
  end

  // Stage B: divide by 10000 through the reciprocal, then clamp
  always_comb begin
    prod   = (NW+RW)'(n_q) * (NW+RW)'(RECIP);
    quo    = (NW+RW-RECIP_SH)'(prod >> RECIP_SH);
    byte_d = (quo > (NW+RW-RECIP_SH)'(255)) ? {CH_W{1'b1}} : CH_W'(quo);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

### rtl/core/hsp_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_pipe
// Shade datapath: adjust, HSL to RGB in fixed point, round and pack.
// ----------------------------------------------------------------------------
module hsp_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsp_pkg::hsp_seq_t seq_i,
  output logic              adv_o,
  hsp_out_if.source         out_o
);
  import hsp_pkg::*;

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, out_valid_q;
  logic [KW-1:0] k1_q, k2_q, k3_q, k4_q, k5_q, k6_q, k7_q, out_k_q;

  // Stage 1: shade adjustment and hue reduction
  logic [PW-1:0]        lig100, sprod;
  logic signed [AW-1:0] lt;
  logic [LW-1:0]        l1_d, l1_q, s1_d, s1_q;
  logic [HUE_W-1:0]     hbase;
  logic [HW-1:0]        h1_d, h1_q;

  always_comb begin
    lig100 = PW'(seq_i.lig) * PW'(100);
    lt     = $signed(AW'(lig100)) + (AW'(LIGHT_OFF[seq_i.k]) <<< FRAC_BITS);
    if (lt < 0) begin
      l1_d = '0;
    end else if (lt > $signed(AW'(DSCALE))) begin
      l1_d = LW'(DSCALE);
    end else begin
      l1_d = LW'(lt);
    end
    sprod = PW'(seq_i.sat) * PW'(SAT_FAC[seq_i.k]);
    s1_d  = (MW'(sprod) > MW'(DSCALE)) ? LW'(DSCALE) : LW'(sprod);
    hbase = '0;
    for (int w = 1; w <= HUE_WRAPS; w++) begin
      if (seq_i.hue >= HUE_W'(w * HUE_PERIOD)) hbase = HUE_W'(w * HUE_PERIOD);
    end
    h1_d = HW'(seq_i.hue - hbase);
  end

  // Stage 2: |2l - 1| and hue sector
  logic [LW:0]     twol, dev;
  logic [LW-1:0]   dm2_d, dm2_q, l2_q, s2_q;
  logic [HW-1:0]   sbase;
  logic [SECW-1:0] sec2_d, sec2_q;
  logic [TW-1:0]   f2, t2_d, t2_q;

  always_comb begin
    twol = (LW+1)'(l1_q) << 1;
    dev  = (twol >= (LW+1)'(DSCALE)) ? twol - (LW+1)'(DSCALE) : (LW+1)'(DSCALE) - twol;
    dm2_d  = LW'((LW+1)'(DSCALE) - dev);
    sec2_d = '0;
    sbase  = '0;
    for (int s = 1; s < SECTORS; s++) begin
      if (h1_q >= HW'(s * SECTOR_LEN)) begin
        sec2_d = SECW'(s);
        sbase  = HW'(s * SECTOR_LEN);
      end
    end
    f2   = TW'(h1_q - sbase);
    t2_d = sec2_d[0] ? TW'(SECTOR_LEN) - f2 : f2;
  end

  // Stage 3: chroma and lightness term
  logic [CW-1:0]   c3_d, c3_q;
  logic [VW-1:0]   lt3_d, lt3_q;
  logic [SECW-1:0] sec3_q;
  logic [TW-1:0]   t3_q;

  always_comb begin
    c3_d  = CW'(dm2_q) * CW'(s2_q);
    lt3_d = VW'(l2_q) * VW'(DSCALE * 1920);
  end

  // Stage 4: c, x and m at common scale D^2 * 1920
  logic [VW-1:0]   cc4_d, cc4_q, xx4_d, xx4_q, mm4_d, mm4_q;
  logic [SECW-1:0] sec4_q;

  always_comb begin
    cc4_d = VW'(c3_q) * VW'(1920);
    xx4_d = VW'(c3_q) * VW'({t3_q, 1'b0});
    mm4_d = lt3_q - VW'(c3_q) * VW'(960);
  end

  // Stage 5: sector routing plus m
  logic [VW-1:0] r5, g5, b5;
  logic [VW-1:0] vr5_d, vg5_d, vb5_d, vr5_q, vg5_q, vb5_q;

  always_comb begin
    unique case (sec4_q)
      SECW'(0): begin r5 = cc4_q; g5 = xx4_q; b5 = '0;    end
      SECW'(1): begin r5 = xx4_q; g5 = cc4_q; b5 = '0;    end
      SECW'(2): begin r5 = '0;    g5 = cc4_q; b5 = xx4_q; end
      SECW'(3): begin r5 = '0;    g5 = xx4_q; b5 = cc4_q; end
      SECW'(4): begin r5 = xx4_q; g5 = '0;    b5 = cc4_q; end
      default:  begin r5 = cc4_q; g5 = '0;    b5 = xx4_q; end
    endcase
    vr5_d = r5 + mm4_q;
    vg5_d = g5 + mm4_q;
    vb5_d = b5 + mm4_q;
  end

  // Stages 6 and 7: per-channel rounding
  logic [CH_W-1:0] r7, g7, b7;

  hsp_chan u_chan_r (.clk_i(clk_i), .en_i(adv), .v_i(vr5_q), .byte_o(r7));
  hsp_chan u_chan_g (.clk_i(clk_i), .en_i(adv), .v_i(vg5_q), .byte_o(g7));
  hsp_chan u_chan_b (.clk_i(clk_i), .en_i(adv), .v_i(vb5_q), .byte_o(b7));

  logic [PIX_W-1:0] pix_q;

  // Whole pipeline moves together; it only holds when the output is full and stalled
  assign adv   = !out_valid_q || out_o.ready;
  assign adv_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= seq_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      out_valid_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k1_q   <= seq_i.k;
      l1_q   <= l1_d;
      s1_q   <= s1_d;
      h1_q   <= h1_d;

      k2_q   <= k1_q;
      l2_q   <= l1_q;
      s2_q   <= s1_q;
      dm2_q  <= dm2_d;
      sec2_q <= sec2_d;
      t2_q   <= t2_d;

      k3_q   <= k2_q;
      c3_q   <= c3_d;
      lt3_q  <= lt3_d;
      sec3_q <= sec2_q;
      t3_q   <= t2_q;

      k4_q   <= k3_q;
      cc4_q  <= cc4_d;
      xx4_q  <= xx4_d;
      mm4_q  <= mm4_d;
      sec4_q <= sec3_q;

      k5_q   <= k4_q;
      vr5_q  <= vr5_d;
      vg5_q  <= vg5_d;
      vb5_q  <= vb5_d;

      k6_q   <= k5_q;
      k7_q   <= k6_q;

      out_k_q <= k7_q;
      pix_q   <= {r7[7:3], g7[7:2], b7[7:3]};
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.shade_index = out_k_q;
  assign out_o.pixel565    = pix_q;
  assign out_o.last        = (out_k_q == LAST_SHADE);

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks hsl_shade_palette_rgb565_core one shade at a time. Base colors go in
// over the input channel. For each color taken, an exact integer model of the
// shade adjustment and HSL to RGB565 conversion queues the eleven expected
// shades. Every shade that leaves the core is compared with the oldest entry.
// Both channels idle at random. There is one long output hold-off and one
// pause that lets the core drain.
// ----------------------------------------------------------------------------
module testbench;
  import hsp_pkg::*;

  localparam int NUM_SHADES = 11;
  localparam int HUE_MOD    = 5760;
  localparam int SECTOR     = 960;
  localparam int TAIL_CYCLES = 24;

  // Shade tables in hundredths, lightest first
  localparam int SHADE_LIFT [NUM_SHADES] = '{35, 28, 20, 12, 6, 0, -8, -16, -26, -38, -48};
  localparam int SHADE_SAT  [NUM_SHADES] = '{35, 50, 70, 85, 95, 100, 95, 85, 70, 55, 40};

  typedef struct {
    logic [KW-1:0]    shade_index;
    logic [PIX_W-1:0] pixel565;
    logic             last;
  } shade_t;

  logic clk_i;
  logic rst_ni;

  hsp_in_if  in_if ();
  hsp_out_if out_if ();

  hsl_shade_palette_rgb565_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  shade_t pending_shades [$];
  int     mismatch_count = 0;
  bit     gaps_on   = 1'b0;
  bit     stalls_on = 1'b0;
  int     hold_cnt  = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Exact model of one shade
  // -------------------------------------------------------------------------
  function automatic logic [7:0] round_channel(longint unsigned v, longint unsigned d2);
    longint unsigned q;
    // v*255/(d2*1920) == v*17/(d2*128), plus one half for rounding
    q = (v * 17 + d2 * 64) / (d2 * 128);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] shade_pixel565(logic [HUE_W-1:0] hue,
                                                      logic [FRAC_IN_W-1:0] sat,
                                                      logic [FRAC_IN_W-1:0] lig,
                                                      int k);
    longint unsigned one, d, d2, l, s, twol, dev, c, cc, xx, mm, r1, g1, b1;
    longint          lt;
    int unsigned     h, sector, f, tnum;
    logic [7:0]      r, g, b;
    one = 64'd1 << FRAC_BITS;
    d   = 100 * one;
    d2  = d * d;

    lt = longint'(lig) * 100 + longint'(SHADE_LIFT[k]) * longint'(one);
    if (lt < 0) lt = 0;
    if (lt > longint'(d)) lt = longint'(d);
    l = longint'(lt);

    s = longint'(sat) * longint'(SHADE_SAT[k]);
    if (s > d) s = d;

    twol = 2 * l;
    dev  = (twol >= d) ? twol - d : d - twol;
    c    = (d - dev) * s;

    h      = hue % HUE_MOD;
    sector = h / SECTOR;
    f      = h % SECTOR;
    tnum   = sector[0] ? SECTOR - f : f;

    cc = c * 1920;
    xx = c * 2 * tnum;
    mm = l * d * 1920 - c * 960;

    case (sector)
      0: begin r1 = cc; g1 = xx; b1 = 0;  end
      1: begin r1 = xx; g1 = cc; b1 = 0;  end
      2: begin r1 = 0;  g1 = cc; b1 = xx; end
      3: begin r1 = 0;  g1 = xx; b1 = cc; end
      4: begin r1 = xx; g1 = 0;  b1 = cc; end
      default: begin r1 = cc; g1 = 0; b1 = xx; end
    endcase

    r = round_channel(r1 + mm, d2);
    g = round_channel(g1 + mm, d2);
    b = round_channel(b1 + mm, d2);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  task automatic predict_palette(logic [HUE_W-1:0] hue, logic [FRAC_IN_W-1:0] sat,
                                 logic [FRAC_IN_W-1:0] lig);
    shade_t sh;
    for (int k = 0; k < NUM_SHADES; k++) begin
      sh.shade_index = KW'(k);
      sh.pixel565    = shade_pixel565(hue, sat, lig, k);
      sh.last        = (k == NUM_SHADES - 1);
      pending_shades.push_back(sh);
    end
  endtask

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------
  task automatic send_color(logic [HUE_W-1:0] hue, logic [FRAC_IN_W-1:0] sat,
                            logic [FRAC_IN_W-1:0] lig);
    int gap;
    gap = 0;
    while (gaps_on && $urandom_range(0, 99) < 26) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.hue        <= hue;
    in_if.saturation <= sat;
    in_if.lightness  <= lig;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_palette(hue, sat, lig);
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_shades.size() != 0) @(posedge clk_i);
  endtask

  // Mostly in range, now and then above one or at the ends
  function automatic logic [FRAC_IN_W-1:0] rand_frac();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)  return '0;
    if (pick < 10) return FRAC_IN_W'(4096);
    if (pick < 20) return FRAC_IN_W'($urandom_range(4097, 8191));
    return FRAC_IN_W'($urandom_range(0, 4096));
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      send_color(HUE_W'($urandom_range(0, 65535)), rand_frac(), rand_frac());
    end
  endtask

  // -------------------------------------------------------------------------
  // Receiver: random stalls plus a counted hold-off
  // -------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(stalls_on && $urandom_range(0, 99) < 26);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Checker
  // -------------------------------------------------------------------------
  task automatic report_mismatch(string what, int expected, int got);
    $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, expected, got);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    shade_t exp_sh;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_shades.size() == 0) begin
        report_mismatch("unexpected shade", 0, out_if.pixel565);
      end else begin
        exp_sh = pending_shades.pop_front();
        if (out_if.shade_index !== exp_sh.shade_index)
          report_mismatch("shade_index", exp_sh.shade_index, out_if.shade_index);
        if (out_if.pixel565 !== exp_sh.pixel565)
          report_mismatch("pixel565", exp_sh.pixel565, out_if.pixel565);
        if (out_if.last !== exp_sh.last)
          report_mismatch("last", exp_sh.last, out_if.last);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_field_extremes();
    send_color(16'd0,      13'd0,    13'd0);
    send_color(16'hFFFF,   13'h1FFF, 13'h1FFF);
    send_color(16'd0,      13'd4096, 13'd4096);
    send_color(16'hFFFF,   13'd4096, 13'd0);
    send_color(16'h5555,   13'h0AAA, 13'h1555);
    send_color(16'hAAAA,   13'h1555, 13'h0AAA);
  endtask

  // Sector edges and hue wrap
  task automatic test_hue_sectors();
    send_color(16'd959,  13'd4096, 13'd2048);
    send_color(16'd960,  13'd4096, 13'd2048);
    send_color(16'd1920, 13'd4096, 13'd2048);
    send_color(16'd2880, 13'd4096, 13'd2048);
    send_color(16'd3840, 13'd4096, 13'd2048);
    send_color(16'd4800, 13'd4096, 13'd2048);
    send_color(16'd5759, 13'd4096, 13'd2048);
    send_color(16'd5760, 13'd4096, 13'd2048);
  endtask

  task automatic test_gray();
    send_color(16'd1234, 13'd0, 13'd2048);
    send_color(16'd4000, 13'd0, 13'd1);
  endtask

  // Saturation or lightness above one, clamped after the shade adjustment
  task automatic test_above_one();
    send_color(16'd300,   13'h1FFF, 13'd2048);
    send_color(16'd2500,  13'd3000, 13'h1FFF);
    send_color(16'd40000, 13'd5000, 13'd5000);
  endtask

  task automatic test_random_no_idle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_random(40);
  endtask

  // Output held off long enough that the core fills and stops taking colors
  task automatic test_output_holdoff();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    hold_cnt  = 80;
    send_random(10);
  endtask

  task automatic test_drain_pause();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_random(4);
    stop_sending();
    wait_drained();
    send_random(4);
  endtask

  task automatic test_random_idle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_random(200);
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.hue        = '0;
    in_if.saturation = '0;
    in_if.lightness  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_hue_sectors();
    test_gray();
    test_above_one();
    test_random_no_idle();
    test_output_holdoff();
    test_drain_pause();
    test_random_idle();

    stop_sending();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[hsl_shade_palette_rgb565_core] OK");
    end else begin
      $display("[hsl_shade_palette_rgb565_core] ERROR");
    end
    $finish;
  end

  // Far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("[hsl_shade_palette_rgb565_core] ERROR");
    $finish;
  end

endmodule

### files.f
rtl/core/hsp_pkg.sv
rtl/core/hsp_if.sv
rtl/core/hsp_seq.sv
rtl/core/hsp_chan.sv
rtl/core/hsp_pipe.sv
rtl/core/hsl_shade_palette_rgb565_core.sv
bench/testbench.sv
